// ----- rtl/core/sida_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg
// Shared widths, character codes and constant helpers for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [DIGIT_W-1:0] t_digit;

    // 10^n as a 64-bit constant, evaluated at elaboration only.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sida_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sida_cell
// One shift-and-add-3 step: correct every BCD digit, then shift one
// binary bit into the BCD field.
// ----------------------------------------------------------------------------
module sida_cell #(
    parameter int DIGITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic                          i_neg,
    input  wire logic [DIGITS-1:0][3:0]        i_bcd,
    input  wire logic [sida_pkg::VALUE_W-1:0]  i_bin,
    output logic                               o_valid,
    output logic                               o_neg,
    output logic [DIGITS-1:0][3:0]             o_bcd,
    output logic [sida_pkg::VALUE_W-1:0]       o_bin
);
    import sida_pkg::*;

    logic                     r_valid;
    logic                     r_neg;
    logic [DIGITS-1:0][3:0]   r_bcd;
    logic [VALUE_W-1:0]       r_bin;
    logic [DIGITS-1:0][3:0]   adj;
    logic [DIGITS*4-1:0]      adj_flat;
    logic [DIGITS-1:0][3:0]   n_bcd;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            adj[d] = (i_bcd[d] >= 4'd5) ? (i_bcd[d] + 4'd3) : i_bcd[d];
        end
        adj_flat = adj;
        n_bcd    = {adj_flat[DIGITS*4-2:0], i_bin[VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_bin <= {i_bin[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule
`default_nettype wire

// ----- rtl/core/sida_ser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sida_ser
// Character serializer: emits an optional minus sign and then the BCD
// digits from the first nonzero one down to the units place.
// ----------------------------------------------------------------------------
module sida_ser #(
    parameter int DIGITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_neg,
    input  wire logic [DIGITS-1:0][3:0]        i_bcd,
    output logic                               o_ready,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sida_pkg::CHAR_W-1:0]        o_text_char,
    output logic                               o_last_char
);
    import sida_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                     r_busy;
    logic                     r_sign;
    logic [IDX_W-1:0]         r_idx;
    logic [DIGITS-1:0][3:0]   r_bcd;
    logic [IDX_W-1:0]         top_idx;
    t_digit                   cur_digit;
    logic                     done;
    logic                     load;

    // Highest nonzero digit; zero renders from the units place.
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[d] != 4'd0) begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit   = r_bcd[r_idx];
    assign o_last_char = !r_sign && (r_idx == '0);
    assign o_text_char = r_sign ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_digit});
    assign o_valid     = r_busy;
    assign done        = r_busy && !i_stall && o_last_char;
    assign o_ready     = !r_busy || done;
    assign load        = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready) begin
            r_busy <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sign <= i_neg;
            r_idx  <= top_idx;
            r_bcd  <= i_bcd;
        end else if (r_busy && !i_stall) begin
            // advance: drop the sign first, then step down one place
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
`default_nettype none
// An accepted value goes through the front register, the conversion cells and the serializer.
// Throughput: 1 character per cycle while i_stall is low; a value takes 1 to 11 characters
//   (sign plus significant digits), set by the character serializer on the output port.
// Input and conversion pipeline move together and hold while the serializer
//   cannot take the next converted value.
// Reset: synchronous, active low; clears all valid flags and the serializer.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [sida_pkg::VALUE_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sida_pkg::CHAR_W-1:0]        o_text_char,
    output logic                               o_last_char
);
    import sida_pkg::*;

    // Largest magnitude that fits in MAX_DIGITS places; larger ones saturate.
    localparam logic [63:0] LIMIT = pow10(MAX_DIGITS) - 64'd1;
    // One double-dabble cell per magnitude bit.
    localparam int CELLS = VALUE_W;

    // Stage 0 is the front register; stage CELLS holds the finished BCD.
    logic [CELLS:0]                      st_valid;
    logic [CELLS:0]                      st_neg;
    logic [CELLS:0][MAX_DIGITS-1:0][3:0] st_bcd;
    logic [CELLS:0][VALUE_W-1:0]         st_bin;

    logic                r_valid0;
    logic                r_neg0;
    logic [VALUE_W-1:0]  r_mag0;
    logic [VALUE_W-1:0]  mag;
    logic                ser_ready;
    logic                adv;

    // The whole chain advances together; hold it only when its tail is
    // occupied and the serializer is still busy with an earlier value.
    assign adv     = !st_valid[CELLS] || ser_ready;
    assign o_stall = !adv;

    // Two's complement magnitude; the most negative value yields 2^31,
    // which an unsigned 32-bit word carries exactly.
    assign mag = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (adv) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_neg0 <= i_value[VALUE_W-1];
            // saturate magnitudes that overflow the configured places
            r_mag0 <= ({32'd0, mag} > LIMIT) ? LIMIT[VALUE_W-1:0] : mag;
        end
    end

    assign st_valid[0] = r_valid0;
    assign st_neg[0]   = r_neg0;
    assign st_bcd[0]   = '0;
    assign st_bin[0]   = r_mag0;

    // Conversion chain: each cell shifts one magnitude bit into BCD.
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        sida_cell #(
            .DIGITS (MAX_DIGITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (st_valid[c]),
            .i_neg   (st_neg[c]),
            .i_bcd   (st_bcd[c]),
            .i_bin   (st_bin[c]),
            .o_valid (st_valid[c+1]),
            .o_neg   (st_neg[c+1]),
            .o_bcd   (st_bcd[c+1]),
            .o_bin   (st_bin[c+1])
        );
    end

    // Serializer: sign, then significant digits, last one flagged.
    sida_ser #(
        .DIGITS (MAX_DIGITS)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (st_valid[CELLS]),
        .i_neg       (st_neg[CELLS]),
        .i_bcd       (st_bcd[CELLS]),
        .o_ready     (ser_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
`default_nettype wire

// ----- rtl/core/sida_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks for the decimal ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
module sida_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_stall,
    input  wire logic [sida_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic [sida_pkg::CHAR_W-1:0]   o_text_char,
    input  wire logic                          o_last_char
);
    import sida_pkg::*;

    // Reset clears the output side.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Hold a stalled transaction.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_text_char)
                                  && $stable(o_last_char)))
        else $error("stalled character changed");

    // Emit only a minus sign or a decimal digit.
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_text_char == CHAR_MINUS
                     || (o_text_char >= CHAR_ZERO && o_text_char <= CHAR_NINE)))
        else $error("illegal character code");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_char == CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
`default_nettype wire
